// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the deframer RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

// ----- rtl/core/kfd_pkg.sv -----
// Shared types, constants and the CRC-32 byte step for the keyed frame deframer.
// No dependencies; used by every module of the block.
package kfd_pkg;

    localparam int DEF_MAX_KEYS   = 8;
    localparam int DEF_FIFO_DEPTH = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT = 2'd3;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [7:0]  CRC_BYTES = 8'd4;

    localparam int TDATA_W = 72;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_CMD  = 3'd1,
        PH_LEN  = 3'd2,
        PH_DATA = 3'd3,
        PH_CRC  = 3'd4,
        PH_ACK  = 3'd5,
        PH_END  = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        KIND_PAYLOAD = 3'd0,
        KIND_OK      = 3'd1,
        KIND_CRC_BAD = 3'd2,
        KIND_TRUNC   = 3'd3,
        KIND_NOFRAME = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [7:0]  command;
        logic [2:0]  command_slot;
        logic [7:0]  payload_length;
        logic [7:0]  ack_value;
        logic [31:0] received_crc;
    } t_result;

    // Reflected CRC-32, one byte, LSB first.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/kfd_front.sv -----
// Front end: configuration registers, frame parser and result classification.
// Depends on kfd_pkg and assert_macros.svh; pushes result records into the queue.
`include "assert_macros.svh"

module kfd_front #(
    parameter int MAX_KEYS = kfd_pkg::DEF_MAX_KEYS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [kfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    input  logic [7:0]                     i_byte,
    input  logic                           i_last,
    input  logic                           i_space,
    output logic                           o_ready,
    output logic                           o_push,
    output kfd_pkg::t_result               o_res
);

    localparam int KEY_W = 8 * MAX_KEYS;

    logic [7:0]       r_header;
    logic [7:0]       r_end;
    logic [KEY_W-1:0] r_keys;
    logic [3:0]       r_key_count;

    kfd_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_cmd, n_cmd;
    logic [2:0]      r_slot, n_slot;
    logic [7:0]      r_len, n_len;
    logic [7:0]      r_count, n_count;
    logic [31:0]     r_crc, n_crc;
    logic [31:0]     r_crc_rx, n_crc_rx;
    logic [7:0]      r_ack, n_ack;
    logic            r_done, n_done;

    kfd_pkg::t_phase w_step_phase;
    kfd_pkg::t_kind  w_kind;
    logic            w_outcome;
    logic            w_crc_bad;
    logic            w_has;
    logic            w_accept;
    logic            w_match;
    logic [2:0]      w_match_slot;
    logic [7:0]      w_count_inc;

    assign o_ready     = i_space;
    assign w_accept    = i_valid && i_space;
    assign w_crc_bad   = (r_crc ^ kfd_pkg::CRC_INIT) != r_crc_rx;
    assign w_count_inc = r_count + 8'd1;

    // Lowest matching slot among the first key_count keys.
    always_comb begin
        w_match      = 1'b0;
        w_match_slot = 3'd0;
        for (int i = 0; i < MAX_KEYS; i++) begin
            if (!w_match && (4'(i) < r_key_count) && (r_keys[8*i +: 8] == i_byte)) begin
                w_match      = 1'b1;
                w_match_slot = 3'(i);
            end
        end
    end

    // Next state
    always_comb begin
        w_step_phase = r_phase;
        w_outcome    = 1'b0;
        n_cmd        = r_cmd;
        n_slot       = r_slot;
        n_len        = r_len;
        n_count      = r_count;
        n_crc        = r_crc;
        n_crc_rx     = r_crc_rx;
        n_ack        = r_ack;
        unique case (r_phase)
            kfd_pkg::PH_CMD: begin
                w_step_phase = kfd_pkg::PH_HUNT;
                if (w_match) begin
                    n_cmd        = i_byte;
                    n_slot       = w_match_slot;
                    w_step_phase = kfd_pkg::PH_LEN;
                end
            end
            kfd_pkg::PH_LEN: begin
                n_len        = i_byte;
                n_count      = 8'd0;
                n_crc        = kfd_pkg::CRC_INIT;
                n_crc_rx     = 32'd0;
                n_ack        = 8'd0;
                w_step_phase = (i_byte != 8'd0) ? kfd_pkg::PH_DATA : kfd_pkg::PH_CRC;
            end
            kfd_pkg::PH_DATA: begin
                n_crc   = kfd_pkg::crc_byte(r_crc, i_byte);
                n_count = w_count_inc;
                if (w_count_inc == r_len) begin
                    n_count      = 8'd0;
                    w_step_phase = kfd_pkg::PH_CRC;
                end
            end
            kfd_pkg::PH_CRC: begin
                n_crc_rx = {r_crc_rx[23:0], i_byte};
                n_count  = w_count_inc;
                if (w_count_inc >= kfd_pkg::CRC_BYTES) begin
                    n_count      = 8'd0;
                    w_step_phase = kfd_pkg::PH_ACK;
                end
            end
            kfd_pkg::PH_ACK: begin
                n_ack        = i_byte;
                w_step_phase = kfd_pkg::PH_END;
            end
            kfd_pkg::PH_END: begin
                if (w_crc_bad || (i_byte == r_end)) begin
                    w_outcome = 1'b1;
                end else begin
                    // bad closing byte: it may itself start the next frame
                    w_step_phase = (i_byte == r_header) ? kfd_pkg::PH_CMD
                                                        : kfd_pkg::PH_HUNT;
                end
            end
            default: begin
                w_step_phase = (i_byte == r_header) ? kfd_pkg::PH_CMD : kfd_pkg::PH_HUNT;
            end
        endcase

        if (r_done) begin
            n_phase = i_last ? kfd_pkg::PH_HUNT : r_phase;
            n_done  = !i_last;
        end else begin
            n_phase = (i_last || w_outcome) ? kfd_pkg::PH_HUNT : w_step_phase;
            n_done  = !i_last && w_outcome;
        end
    end

    // Outputs: result record for this request
    always_comb begin
        w_has  = 1'b0;
        w_kind = kfd_pkg::KIND_PAYLOAD;
        if (!r_done) begin
            priority if (w_outcome) begin
                w_has  = 1'b1;
                w_kind = w_crc_bad ? kfd_pkg::KIND_CRC_BAD : kfd_pkg::KIND_OK;
            end else if (i_last) begin
                w_has  = 1'b1;
                w_kind = ((w_step_phase >= kfd_pkg::PH_LEN) && (w_step_phase <= kfd_pkg::PH_END))
                         ? kfd_pkg::KIND_TRUNC : kfd_pkg::KIND_NOFRAME;
            end else if (r_phase == kfd_pkg::PH_DATA) begin
                w_has = 1'b1;
            end
        end

        o_push               = w_accept && w_has;
        o_res.kind           = w_kind;
        o_res.data_byte      = (w_kind == kfd_pkg::KIND_PAYLOAD) ? i_byte : 8'd0;
        o_res.command        = (w_kind != kfd_pkg::KIND_NOFRAME) ? n_cmd : 8'd0;
        o_res.command_slot   = (w_kind != kfd_pkg::KIND_NOFRAME) ? n_slot : 3'd0;
        o_res.payload_length = (w_kind != kfd_pkg::KIND_NOFRAME) ? n_len : 8'd0;
        o_res.ack_value      = (w_kind == kfd_pkg::KIND_OK) ? n_ack : 8'd0;
        o_res.received_crc   = ((w_kind == kfd_pkg::KIND_OK) || (w_kind == kfd_pkg::KIND_CRC_BAD))
                               ? n_crc_rx : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header    <= 8'd0;
            r_end       <= 8'd0;
            r_keys      <= '0;
            r_key_count <= 4'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                kfd_pkg::CFG_HEADER:    r_header    <= i_cfg_data[7:0];
                kfd_pkg::CFG_END:       r_end       <= i_cfg_data[7:0];
                kfd_pkg::CFG_KEY_BYTES: r_keys      <= i_cfg_data[KEY_W-1:0];
                kfd_pkg::CFG_KEY_COUNT: r_key_count <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= kfd_pkg::PH_HUNT;
            r_cmd    <= 8'd0;
            r_slot   <= 3'd0;
            r_len    <= 8'd0;
            r_count  <= 8'd0;
            r_crc    <= kfd_pkg::CRC_INIT;
            r_crc_rx <= 32'd0;
            r_ack    <= 8'd0;
            r_done   <= 1'b0;
        end else if (w_accept) begin
            r_phase  <= n_phase;
            r_cmd    <= n_cmd;
            r_slot   <= n_slot;
            r_len    <= n_len;
            r_count  <= n_count;
            r_crc    <= n_crc;
            r_crc_rx <= n_crc_rx;
            r_ack    <= n_ack;
            r_done   <= n_done;
        end
    end

    `ASSERT_CLK(a_done_hunts, i_clk, i_rst_n, r_done |-> (r_phase == kfd_pkg::PH_HUNT), "buffer done outside hunt phase")
    `ASSERT_CLK(a_payload_from_data, i_clk, i_rst_n, (o_push && (o_res.kind == kfd_pkg::KIND_PAYLOAD)) |-> (r_phase == kfd_pkg::PH_DATA), "payload echo outside data phase")

endmodule

// ----- rtl/core/kfd_fifo.sv -----
// Short result queue between the parser and the output stage.
// Depends on kfd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kfd_fifo #(
    parameter int DEPTH = kfd_pkg::DEF_FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  kfd_pkg::t_result i_res,
    input  logic             i_pop,
    output logic             o_space,
    output logic             o_valid,
    output kfd_pkg::t_result o_res
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    kfd_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count;

    assign o_space = r_count != CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_res   = r_mem[r_rd];
    assign n_wr    = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
    assign n_rd    = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= n_wr;
            if (i_pop)  r_rd <= n_rd;
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && !o_space, "push into full queue")
    `ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && !o_valid, "pop from empty queue")

endmodule

// ----- rtl/core/kfd_back.sv -----
// Back end: output register that drives the result stream.
// Depends on kfd_pkg and assert_macros.svh; pulls records from the queue.
`include "assert_macros.svh"

module kfd_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  kfd_pkg::t_result             i_res,
    output logic                         o_pop,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [kfd_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic [2:0]                   m_axis_tuser
);

    logic             r_valid;
    kfd_pkg::t_result r_res;

    assign o_pop         = i_valid && (!r_valid || m_axis_tready);
    assign m_axis_tvalid = r_valid;
    assign m_axis_tuser  = r_res.kind;
    assign m_axis_tdata  = {5'd0, r_res.received_crc, r_res.ack_value, r_res.payload_length,
                            r_res.command_slot, r_res.command, r_res.data_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_res;
        end
    end

    `ASSERT_CLK(a_fill_empty, i_clk, i_rst_n, (i_valid && !r_valid) |=> r_valid, "queued result not loaded into empty output stage")

endmodule

// ----- rtl/core/keyed_frame_deframer_crc32.sv -----
// Top level of the keyed frame deframer with CRC-32 check.
// Depends on kfd_pkg, kfd_front, kfd_fifo and kfd_back.
//
// Usage:
//   Input stream: one received byte per request in s_axis_tdata, s_axis_tlast
//   set on the final byte of a buffer. Output stream: one result per payload
//   byte and one per frame outcome (ok, CRC mismatch, truncated, no frame);
//   m_axis_tuser carries the kind, m_axis_tdata the fields.
//   Configuration: header byte, end byte, packed keys and key count are written
//   through i_cfg_we / i_cfg_index / i_cfg_data while the block is idle.
//   Throughput: one byte per cycle while the queue has space; parsing, the
//   byte-wise CRC step and the key compare all complete in the front stage in
//   the cycle of acceptance. A result is written into the queue when its byte
//   is accepted and is loaded into the output register from there.
//   Stall: when m_axis_tready is low results collect in the queue of
//   FIFO_DEPTH entries plus the output register; s_axis_tready drops only when
//   the queue is full.
//   Reset: synchronous, active low; the parser hunts for a header, configuration
//   registers and queue pointers clear, and the block is ready right after reset.
module keyed_frame_deframer_crc32 #(
    parameter int MAX_KEYS   = kfd_pkg::DEF_MAX_KEYS,
    parameter int FIFO_DEPTH = kfd_pkg::DEF_FIFO_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [kfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // rx_byte [7:0]
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // data_byte [7:0], command [15:8], command_slot [18:16], payload_length [26:19],
    // ack_value [34:27], received_crc [66:35], zero pad [71:67]
    output logic [kfd_pkg::TDATA_W-1:0]    m_axis_tdata,
    output logic [2:0]                     m_axis_tuser   // kind [2:0]
);

    logic             w_space;
    logic             w_push;
    logic             w_pop;
    logic             w_q_valid;
    kfd_pkg::t_result w_front_res;
    kfd_pkg::t_result w_q_res;

    kfd_front #(
        .MAX_KEYS (MAX_KEYS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_space     (w_space),
        .o_ready     (s_axis_tready),
        .o_push      (w_push),
        .o_res       (w_front_res)
    );

    kfd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res   (w_front_res),
        .i_pop   (w_pop),
        .o_space (w_space),
        .o_valid (w_q_valid),
        .o_res   (w_q_res)
    );

    kfd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_q_valid),
        .i_res         (w_q_res),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ----- dv/keyed_frame_deframer_crc32_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for keyed_frame_deframer_crc32: a byte-level parser model in a
// scoreboard class, directed and random framed buffers, random idling on both streams.
// Depends on kfd_pkg and the deframer RTL.

class deframer_scoreboard;
    kfd_pkg::t_result due_results[$];
    int unsigned      mismatches;
    int unsigned      results_seen;

    // register copies
    logic [7:0]  header_b;
    logic [7:0]  end_b;
    logic [63:0] keys;
    logic [3:0]  key_cnt;

    // parser state
    kfd_pkg::t_phase ph;
    logic [7:0]      cmd;
    logic [2:0]      slot;
    logic [7:0]      len;
    logic [7:0]      cnt;
    logic [31:0]     crc;
    logic [31:0]     crc_rx;
    logic [7:0]      ack;
    logic            done;

    function new();
        mismatches   = 0;
        results_seen = 0;
        header_b     = '0;
        end_b        = '0;
        keys         = '0;
        key_cnt      = '0;
        ph           = kfd_pkg::PH_HUNT;
        cmd          = '0;
        slot         = '0;
        len          = '0;
        cnt          = '0;
        crc          = kfd_pkg::CRC_INIT;
        crc_rx       = '0;
        ack          = '0;
        done         = 1'b0;
    endfunction

    // Reflected CRC-32, message bit i folded into the LSB at step i.
    static function logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
        logic [31:0] r;
        r = c;
        for (int i = 0; i < 8; i++) begin
            r = (r >> 1) ^ ((r[0] ^ b[i]) ? kfd_pkg::CRC_POLY : 32'h0);
        end
        return r;
    endfunction

    function void set_reg(logic [kfd_pkg::CFG_IDX_W-1:0] idx,
                          logic [kfd_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            kfd_pkg::CFG_HEADER:    header_b = val[7:0];
            kfd_pkg::CFG_END:       end_b    = val[7:0];
            kfd_pkg::CFG_KEY_BYTES: keys     = val;
            kfd_pkg::CFG_KEY_COUNT: key_cnt  = val[3:0];
            default: ;
        endcase
    endfunction

    // Advance the parser by one accepted byte and queue what it should produce.
    function void note_request(logic [7:0] b, logic last);
        kfd_pkg::t_result r;
        logic             fired;
        kfd_pkg::t_kind   k;
        int               n;
        if (done) begin
            if (last) begin
                done = 1'b0;
                ph   = kfd_pkg::PH_HUNT;
            end
            return;
        end
        fired = 1'b0;
        k     = kfd_pkg::KIND_NOFRAME;
        case (ph)
            kfd_pkg::PH_CMD: begin
                n  = (key_cnt > kfd_pkg::DEF_MAX_KEYS) ? kfd_pkg::DEF_MAX_KEYS
                                                       : int'(key_cnt);
                ph = kfd_pkg::PH_HUNT;
                // lowest matching slot wins
                for (int i = 0; i < n; i++) begin
                    if (keys[8*i +: 8] == b) begin
                        cmd  = b;
                        slot = 3'(i);
                        ph   = kfd_pkg::PH_LEN;
                        break;
                    end
                end
            end
            kfd_pkg::PH_LEN: begin
                len    = b;
                cnt    = '0;
                crc    = kfd_pkg::CRC_INIT;
                crc_rx = '0;
                ack    = '0;
                ph     = (b != 8'd0) ? kfd_pkg::PH_DATA : kfd_pkg::PH_CRC;
            end
            kfd_pkg::PH_DATA: begin
                crc   = crc_next(crc, b);
                fired = 1'b1;
                k     = kfd_pkg::KIND_PAYLOAD;
                cnt   = cnt + 8'd1;
                if (cnt == len) begin
                    cnt = '0;
                    ph  = kfd_pkg::PH_CRC;
                end
            end
            kfd_pkg::PH_CRC: begin
                crc_rx = {crc_rx[23:0], b};
                cnt    = cnt + 8'd1;
                if (cnt >= kfd_pkg::CRC_BYTES) begin
                    cnt = '0;
                    ph  = kfd_pkg::PH_ACK;
                end
            end
            kfd_pkg::PH_ACK: begin
                ack = b;
                ph  = kfd_pkg::PH_END;
            end
            kfd_pkg::PH_END: begin
                // CRC is judged first, whatever the closing byte is
                if (~crc != crc_rx) begin
                    fired = 1'b1;
                    k     = kfd_pkg::KIND_CRC_BAD;
                end else if (b == end_b) begin
                    fired = 1'b1;
                    k     = kfd_pkg::KIND_OK;
                end else begin
                    ph = (b == header_b) ? kfd_pkg::PH_CMD : kfd_pkg::PH_HUNT;
                end
            end
            default: ph = (b == header_b) ? kfd_pkg::PH_CMD : kfd_pkg::PH_HUNT;
        endcase

        // end of buffer replaces a payload echo with the truncation outcome
        if (last && (!fired || k == kfd_pkg::KIND_PAYLOAD)) begin
            fired = 1'b1;
            k     = (ph >= kfd_pkg::PH_LEN && ph <= kfd_pkg::PH_END) ? kfd_pkg::KIND_TRUNC
                                                                     : kfd_pkg::KIND_NOFRAME;
        end

        if (last) begin
            ph   = kfd_pkg::PH_HUNT;
            done = 1'b0;
        end else if (fired && k != kfd_pkg::KIND_PAYLOAD) begin
            ph   = kfd_pkg::PH_HUNT;
            done = 1'b1;
        end

        if (!fired) return;
        r      = '0;
        r.kind = k;
        if (k == kfd_pkg::KIND_PAYLOAD) r.data_byte = b;
        if (k != kfd_pkg::KIND_NOFRAME) begin
            r.command        = cmd;
            r.command_slot   = slot;
            r.payload_length = len;
        end
        if (k == kfd_pkg::KIND_OK) r.ack_value = ack;
        if (k == kfd_pkg::KIND_OK || k == kfd_pkg::KIND_CRC_BAD) r.received_crc = crc_rx;
        due_results.push_back(r);
    endfunction

    task report(string field, logic [63:0] got, logic [63:0] want);
        mismatches++;
        if (mismatches <= 100)
            $display("mismatch at result %0d, %s: got %0h want %0h",
                     results_seen, field, got, want);
    endtask

    task check_result(logic [2:0] kind, logic [kfd_pkg::TDATA_W-1:0] data);
        kfd_pkg::t_result want;
        results_seen++;
        if (due_results.size() == 0) begin
            report("unexpected result, kind", 64'(kind), 64'h0);
            return;
        end
        want = due_results.pop_front();
        if (kind !== want.kind)                  report("kind", 64'(kind), 64'(want.kind));
        if (data[7:0] !== want.data_byte)        report("data_byte", 64'(data[7:0]),
                                                        64'(want.data_byte));
        if (data[15:8] !== want.command)         report("command", 64'(data[15:8]),
                                                        64'(want.command));
        if (data[18:16] !== want.command_slot)   report("command_slot", 64'(data[18:16]),
                                                        64'(want.command_slot));
        if (data[26:19] !== want.payload_length) report("payload_length", 64'(data[26:19]),
                                                        64'(want.payload_length));
        if (data[34:27] !== want.ack_value)      report("ack_value", 64'(data[34:27]),
                                                        64'(want.ack_value));
        if (data[66:35] !== want.received_crc)   report("received_crc", 64'(data[66:35]),
                                                        64'(want.received_crc));
    endtask
endclass

module keyed_frame_deframer_crc32_tb;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_we      = 1'b0;
    logic [kfd_pkg::CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [kfd_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [7:0]                     s_axis_tdata  = '0;   // rx_byte [7:0]
    logic                           s_axis_tlast  = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // data_byte [7:0], command [15:8], command_slot [18:16], payload_length [26:19],
    // ack_value [34:27], received_crc [66:35], zero pad [71:67]
    logic [kfd_pkg::TDATA_W-1:0]    m_axis_tdata;
    logic [2:0]                     m_axis_tuser;         // kind [2:0]

    deframer_scoreboard sb;

    int unsigned bytes_sent     = 0;
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    logic        hold_armed     = 1'b0;
    logic        hold_done      = 1'b0;
    int unsigned hold_left      = 0;

    keyed_frame_deframer_crc32 u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Result side: random stalls, plus one long hold-off once armed.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_armed && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 400;
            hold_done     <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata);
    end

    // Leaves tvalid high on return; the next call or stop_sending decides its value.
    task automatic send_byte(logic [7:0] b, logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(b, last);
        bytes_sent++;
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic send_buffer(logic [7:0] q[$]);
        foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    endtask

    // Caller lowers i_cfg_we after its last write.
    task automatic write_reg(logic [kfd_pkg::CFG_IDX_W-1:0] idx,
                             logic [kfd_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic configure(logic [7:0] hdr, logic [7:0] eob, logic [63:0] k, logic [3:0] n);
        write_reg(kfd_pkg::CFG_HEADER, 64'(hdr));
        write_reg(kfd_pkg::CFG_END, 64'(eob));
        write_reg(kfd_pkg::CFG_KEY_BYTES, k);
        write_reg(kfd_pkg::CFG_KEY_COUNT, 64'(n));
        i_cfg_we <= 1'b0;
    endtask

    // Ignored bytes give no result, so allow the pipeline to settle after the last one.
    task automatic drain();
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1:       begin src_idle_pct = 67; sink_stall_pct = 0;  end
            2:       begin src_idle_pct = 0;  sink_stall_pct = 67; end
            default: begin src_idle_pct = 34; sink_stall_pct = 34; end
        endcase
    endtask

    // header, command, length, payload, CRC big-endian, ack, closing byte
    function automatic void add_frame(ref logic [7:0] q[$]);
        int          n;
        int          s;
        int          key_slot;
        int          plen;
        logic [31:0] c;
        logic [7:0]  cmd;
        logic [7:0]  pb;
        n = (sb.key_cnt > kfd_pkg::DEF_MAX_KEYS) ? kfd_pkg::DEF_MAX_KEYS : int'(sb.key_cnt);
        if (n > 0 && $urandom_range(0, 99) < 90) begin
            key_slot = $urandom_range(0, n - 1);
            cmd      = sb.keys[8*key_slot +: 8];
        end else begin
            cmd = 8'($urandom);
        end
        s = $urandom_range(0, 99);
        if (s < 6)       plen = 0;
        else if (s < 99) plen = $urandom_range(1, 12);
        else             plen = $urandom_range(150, 255);
        q.push_back(sb.header_b);
        q.push_back(cmd);
        q.push_back(8'(plen));
        c = kfd_pkg::CRC_INIT;
        repeat (plen) begin
            pb = 8'($urandom);
            c  = sb.crc_next(c, pb);
            q.push_back(pb);
        end
        c = ~c;
        if ($urandom_range(0, 99) < 10) c = c ^ (32'h1 << $urandom_range(0, 31));
        for (int i = 3; i >= 0; i--) q.push_back(c[8*i +: 8]);
        q.push_back(8'($urandom));
        s = $urandom_range(0, 99);
        if (s < 85)      q.push_back(sb.end_b);
        else if (s < 92) q.push_back(sb.header_b);   // bad close that restarts a frame
        else             q.push_back(8'($urandom));
    endfunction

    task automatic send_random_buffer();
        logic [7:0] q[$];
        int         cut;
        repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
        if ($urandom_range(0, 99) < 85) add_frame(q);
        if ($urandom_range(0, 99) < 15) add_frame(q);
        repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
        if (q.size() == 0) q.push_back(8'($urandom));
        if ($urandom_range(0, 99) < 15) begin
            cut = $urandom_range(1, q.size());
            while (q.size() > cut) void'(q.pop_back());
        end
        send_buffer(q);
    endtask

    initial begin
        int unsigned target;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // keys: slot 0 = 10, slot 1 = 20, slot 2 = 10 again
        configure(8'h7E, 8'h7F, 64'h0000_0000_0010_2010, 4'd3);
        // good frame with empty payload, then ignored tail
        send_buffer('{8'h7E, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h06, 8'h7F,
                      8'hAA});
        // unknown command, then duplicate key with a bad CRC closed on the last byte
        send_buffer('{8'h7E, 8'h99, 8'h7E, 8'h10, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h15, 8'h00});
        // buffer ends on a payload byte
        send_buffer('{8'h7E, 8'h10, 8'h02, 8'h00});
        send_buffer('{8'h33});
        stop_sending();

        for (int chunk = 0; chunk < 8; chunk++) begin
            drain();
            case (chunk)
                0:       configure(8'h00, 8'hFF, {$urandom, $urandom}, 4'd8);
                1:       configure(8'hFF, 8'h00, {$urandom, $urandom}, 4'd15);
                2:       configure(8'($urandom), 8'($urandom), 64'h0, 4'd1);
                3:       configure(8'($urandom), 8'($urandom), {64{1'b1}}, 4'd2);
                4:       configure(8'($urandom), 8'($urandom), {$urandom, $urandom}, 4'd0);
                default: configure(8'($urandom), 8'($urandom), {$urandom, $urandom},
                                   4'($urandom_range(1, 8)));
            endcase
            set_idling(chunk % 4);
            if (chunk == 0) hold_armed <= 1'b1;
            target = bytes_sent + 240;
            while (bytes_sent < target) send_random_buffer();
            stop_sending();
        end

        drain();
        if (sb.mismatches == 0 && sb.due_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
